// ----- rtl/rrts_pkg.sv -----
`timescale 1ns / 1ps

package rrts_pkg;

    // Fixed field widths of the stream items
    localparam int ID_W        = 6;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int OUT_CNT_W   = 32;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 72;

    // Defaults for the top-level parameters
    localparam int MAX_THREADS_DEF = 64;
    localparam int COUNT_WIDTH_DEF = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SPAWN     = 3'd0;
    localparam logic [OP_W-1:0] OP_TERMINATE = 3'd1;
    localparam logic [OP_W-1:0] OP_BLOCK     = 3'd2;
    localparam logic [OP_W-1:0] OP_UNBLOCK   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK      = 3'd4;
    localparam logic [OP_W-1:0] OP_READ      = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_THREAD    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_SUCCESSOR = 2'd3;

    // Field write enables of the link memory
    typedef struct packed {
        logic nxt;
        logic prv;
    } link_we_t;

    // One result item
    typedef struct packed {
        logic [ID_W-1:0]      running_id;
        logic [STATUS_W-1:0]  status;
        logic [OUT_CNT_W-1:0] thread_quanta;
        logic [OUT_CNT_W-1:0] total_quanta;
    } result_t;

endpackage

// ----- rtl/rrts_link_ram.sv -----
`timescale 1ns / 1ps

module rrts_link_ram #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF,
    localparam int TW = $clog2(MAX_THREADS),
    localparam int LW = TW + 1
) (
    input  logic              clk,
    input  rrts_pkg::link_we_t we,
    input  logic [TW-1:0]     waddr,
    input  logic [LW-1:0]     wnext,
    input  logic [LW-1:0]     wprev,
    input  logic [TW-1:0]     raddr,
    output logic [LW-1:0]     rnext,
    output logic [LW-1:0]     rprev
);

    // Successor link in the upper half, predecessor link in the lower half
    logic [2*LW-1:0] link_mem [MAX_THREADS];
    logic [2*LW-1:0] rd_reg;

    // Write each half under its own enable, register the read
    always_ff @(posedge clk)
    begin
        if (we.nxt)
        begin
            link_mem[waddr][2*LW-1:LW] <= wnext;
        end
        if (we.prv)
        begin
            link_mem[waddr][LW-1:0] <= wprev;
        end
        rd_reg <= link_mem[raddr];
    end

    assign rnext = rd_reg[2*LW-1:LW];
    assign rprev = rd_reg[LW-1:0];

endmodule

// ----- rtl/rrts_info_ram.sv -----
`timescale 1ns / 1ps

module rrts_info_ram #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF,
    parameter int COUNT_WIDTH = rrts_pkg::COUNT_WIDTH_DEF,
    localparam int TW = $clog2(MAX_THREADS),
    localparam int DW = COUNT_WIDTH + 2
) (
    input  logic          clk,
    input  logic          we,
    input  logic [TW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [TW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    // Exists flag, blocked flag and quantum count of each thread
    logic [DW-1:0] info_mem [MAX_THREADS];
    logic [DW-1:0] rd_reg;

    // Write whole entries, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            info_mem[waddr] <= wdata;
        end
        rd_reg <= info_mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

// ----- rtl/rrts_seq.sv -----
`timescale 1ns / 1ps

module rrts_seq #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF,
    parameter int COUNT_WIDTH = rrts_pkg::COUNT_WIDTH_DEF,
    localparam int TW = $clog2(MAX_THREADS),
    localparam int LW = TW + 1,
    localparam int DW = COUNT_WIDTH + 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // command side
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rrts_pkg::OP_W-1:0]   in_op,
    input  logic [rrts_pkg::ID_W-1:0]   in_id,
    // result side
    input  logic                        res_ready,
    output logic                        res_valid,
    output rrts_pkg::result_t           res,
    // link memory
    output rrts_pkg::link_we_t          link_we,
    output logic [TW-1:0]               link_waddr,
    output logic [LW-1:0]               link_wnext,
    output logic [LW-1:0]               link_wprev,
    output logic [TW-1:0]               link_raddr,
    input  logic [LW-1:0]               link_rnext,
    input  logic [LW-1:0]               link_rprev,
    // info memory
    output logic                        info_we,
    output logic [TW-1:0]               info_waddr,
    output logic [DW-1:0]               info_wdata,
    output logic [TW-1:0]               info_raddr,
    input  logic [DW-1:0]               info_rdata
);

    localparam int XW = rrts_pkg::ID_W + TW;
    localparam int CXW = COUNT_WIDTH + rrts_pkg::OUT_CNT_W;
    localparam logic [LW-1:0] NONE = LW'(MAX_THREADS);
    localparam logic [TW-1:0] LAST_IDX = TW'(MAX_THREADS - 1);
    localparam int EX_BIT = COUNT_WIDTH + 1;
    localparam int BL_BIT = COUNT_WIDTH;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_W2   = 3'd3;
    localparam logic [2:0] S_W3   = 3'd4;
    localparam logic [2:0] S_HOLD = 3'd5;

    // control state
    logic [2:0]             state_reg, state_next;
    logic [TW-1:0]          clr_reg, clr_next;
    logic [TW-1:0]          running_reg, running_next;
    logic [LW-1:0]          tail_reg, tail_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic                   inc_reg, inc_next;
    rrts_pkg::link_we_t     b_we_reg, b_we_next;
    rrts_pkg::link_we_t     c_we_reg, c_we_next;

    // payload
    logic [rrts_pkg::OP_W-1:0]     op_reg;
    logic [TW-1:0]                 id_reg;
    logic                          idok_reg;
    logic [rrts_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [COUNT_WIDTH-1:0]        tq_reg, tq_next;
    logic [TW-1:0]                 b_addr_reg, b_addr_next, c_addr_reg, c_addr_next;
    logic [LW-1:0]                 b_nxt_reg, b_nxt_next, c_prv_reg, c_prv_next;
    logic [LW-1:0]                 c_nxt_reg, c_nxt_next;

    // command decode
    logic [XW-1:0] in_ext;
    logic          in_ok;
    logic [TW-1:0] in_idx;

    // read data views
    logic                   rd_exists, rd_blocked;
    logic [COUNT_WIDTH-1:0] rd_quanta, quanta_inc;
    logic                   known, is_run;
    logic [LW-1:0]          run_link, id_link, tail_eff, tail_adv, tail_tick, tail_unl;
    logic [TW-1:0]          nw;

    // evaluation-cycle writes
    rrts_pkg::link_we_t     ev_lwe;
    logic [TW-1:0]          ev_laddr;
    logic [LW-1:0]          ev_lnext, ev_lprev;
    logic                   ev_iwe;
    logic [DW-1:0]          ev_idata;

    // output widening
    logic [XW-1:0]  run_ext;
    logic [CXW-1:0] tq_ext, total_ext;

    assign in_ext = XW'(in_id);
    assign in_ok  = in_ext < XW'(MAX_THREADS);
    assign in_idx = in_ok ? in_ext[TW-1:0] : '0;

    assign rd_exists  = info_rdata[EX_BIT];
    assign rd_blocked = info_rdata[BL_BIT];
    assign rd_quanta  = info_rdata[COUNT_WIDTH-1:0];
    assign quanta_inc = rd_quanta + COUNT_WIDTH'(1);

    assign known    = idok_reg && rd_exists;
    assign is_run   = (id_reg == running_reg);
    assign run_link = LW'(running_reg);
    assign id_link  = LW'(id_reg);
    assign nw       = link_rnext[TW-1:0];

    // Tail seen by an enqueue, after an advance, and after an unlink
    assign tail_eff  = (tail_reg != NONE) ? tail_reg : run_link;
    assign tail_adv  = (tail_reg == link_rnext) ? NONE : tail_reg;
    assign tail_tick = (tail_adv != NONE) ? tail_adv : link_rnext;
    assign tail_unl  = (tail_reg != id_link) ? tail_reg :
                       ((link_rprev == run_link || link_rprev == NONE) ? NONE : link_rprev);

    // Decide the operation once both memory reads have landed
    always_comb
    begin
        ev_lwe       = '0;
        ev_laddr     = id_reg;
        ev_lnext     = NONE;
        ev_lprev     = NONE;
        ev_iwe       = 1'b0;
        ev_idata     = {rd_exists, rd_blocked, rd_quanta};
        status_next  = rrts_pkg::STAT_OK;
        tq_next      = '0;
        b_we_next    = '0;
        b_addr_next  = id_reg;
        b_nxt_next   = NONE;
        c_we_next    = '0;
        c_addr_next  = nw;
        c_prv_next   = link_rprev;
        c_nxt_next   = NONE;
        inc_next     = 1'b0;
        running_next = running_reg;
        tail_next    = tail_reg;
        total_next   = total_reg;

        case (op_reg)
            rrts_pkg::OP_SPAWN:
            begin
                if (!idok_reg)
                begin
                    status_next = rrts_pkg::STAT_NO_THREAD;
                end
                else if (rd_exists)
                begin
                    status_next = rrts_pkg::STAT_DUPLICATE;
                end
                else
                begin
                    ev_iwe        = 1'b1;
                    ev_idata      = {1'b1, 1'b0, {COUNT_WIDTH{1'b0}}};
                    ev_lwe.nxt    = 1'b1;
                    ev_lwe.prv    = 1'b1;
                    ev_lprev      = tail_eff;
                    b_we_next.nxt = 1'b1;
                    b_addr_next   = tail_eff[TW-1:0];
                    b_nxt_next    = id_link;
                    tail_next     = id_link;
                end
            end

            rrts_pkg::OP_TERMINATE:
            begin
                if (!known)
                begin
                    status_next = rrts_pkg::STAT_NO_THREAD;
                end
                else if (is_run && link_rnext == NONE)
                begin
                    // nothing ready: keep running and count the quantum
                    ev_iwe      = 1'b1;
                    ev_idata    = {rd_exists, rd_blocked, quanta_inc};
                    total_next  = total_reg + COUNT_WIDTH'(1);
                    status_next = rrts_pkg::STAT_NO_SUCCESSOR;
                end
                else
                begin
                    ev_iwe     = 1'b1;
                    ev_idata   = '0;
                    ev_lwe.nxt = 1'b1;
                    ev_lwe.prv = 1'b1;
                    if (is_run)
                    begin
                        b_we_next.prv = 1'b1;
                        b_addr_next   = nw;
                        inc_next      = 1'b1;
                        total_next    = total_reg + COUNT_WIDTH'(1);
                        running_next  = nw;
                        tail_next     = tail_adv;
                    end
                    else
                    begin
                        b_we_next.nxt = (link_rprev != NONE);
                        b_addr_next   = link_rprev[TW-1:0];
                        b_nxt_next    = link_rnext;
                        c_we_next.prv = (link_rnext != NONE);
                        tail_next     = tail_unl;
                    end
                end
            end

            rrts_pkg::OP_BLOCK:
            begin
                if (!known)
                begin
                    status_next = rrts_pkg::STAT_NO_THREAD;
                end
                else if (!rd_blocked)
                begin
                    ev_iwe   = 1'b1;
                    ev_idata = {1'b1, 1'b1, rd_quanta};
                    if (!is_run)
                    begin
                        ev_lwe.nxt    = 1'b1;
                        ev_lwe.prv    = 1'b1;
                        b_we_next.nxt = (link_rprev != NONE);
                        b_addr_next   = link_rprev[TW-1:0];
                        b_nxt_next    = link_rnext;
                        c_we_next.prv = (link_rnext != NONE);
                        tail_next     = tail_unl;
                    end
                end
            end

            rrts_pkg::OP_UNBLOCK:
            begin
                if (!known)
                begin
                    status_next = rrts_pkg::STAT_NO_THREAD;
                end
                else if (rd_blocked)
                begin
                    ev_iwe   = 1'b1;
                    ev_idata = {1'b1, 1'b0, rd_quanta};
                    if (!is_run)
                    begin
                        ev_lwe.nxt    = 1'b1;
                        ev_lwe.prv    = 1'b1;
                        ev_lprev      = tail_eff;
                        b_we_next.nxt = 1'b1;
                        b_addr_next   = tail_eff[TW-1:0];
                        b_nxt_next    = id_link;
                        tail_next     = id_link;
                    end
                end
            end

            rrts_pkg::OP_TICK:
            begin
                ev_laddr   = running_reg;
                total_next = total_reg + COUNT_WIDTH'(1);
                if (link_rnext == NONE)
                begin
                    ev_iwe   = 1'b1;
                    ev_idata = {rd_exists, rd_blocked, quanta_inc};
                end
                else
                begin
                    b_we_next.prv = 1'b1;
                    b_addr_next   = nw;
                    inc_next      = 1'b1;
                    running_next  = nw;
                    tail_next     = tail_adv;
                    ev_lwe.nxt    = 1'b1;
                    if (!rd_blocked)
                    begin
                        // requeue the preempted thread at the tail
                        ev_lwe.prv    = 1'b1;
                        ev_lprev      = tail_tick;
                        c_we_next.nxt = 1'b1;
                        c_addr_next   = tail_tick[TW-1:0];
                        c_nxt_next    = run_link;
                        tail_next     = run_link;
                    end
                end
            end

            rrts_pkg::OP_READ:
            begin
                if (!known)
                begin
                    status_next = rrts_pkg::STAT_NO_THREAD;
                end
                else
                begin
                    tq_next = rd_quanta;
                end
            end

            default:
            begin
                status_next = rrts_pkg::STAT_OK;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            S_CLR:
            begin
                clr_next = clr_reg + TW'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_W2;
            end
            S_W2:
            begin
                state_next = S_W3;
            end
            S_W3, S_HOLD:
            begin
                state_next = res_ready ? S_IDLE : S_HOLD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_W3 || state_reg == S_HOLD) && res_ready;

    // Memory read addresses: command thread on accept (running thread for a tick), successor during evaluation
    assign link_raddr = (in_op == rrts_pkg::OP_TICK) ? running_reg : in_idx;
    assign info_raddr = (state_reg == S_EVAL) ? nw : link_raddr;

    // Link memory write port
    always_comb
    begin
        link_we    = '0;
        link_waddr = clr_reg;
        link_wnext = NONE;
        link_wprev = NONE;
        case (state_reg)
            S_CLR:
            begin
                link_we.nxt = 1'b1;
                link_we.prv = 1'b1;
            end
            S_EVAL:
            begin
                link_we    = ev_lwe;
                link_waddr = ev_laddr;
                link_wnext = ev_lnext;
                link_wprev = ev_lprev;
            end
            S_W2:
            begin
                link_we    = b_we_reg;
                link_waddr = b_addr_reg;
                link_wnext = b_nxt_reg;
            end
            S_W3:
            begin
                link_we    = c_we_reg;
                link_waddr = c_addr_reg;
                link_wnext = c_nxt_reg;
                link_wprev = c_prv_reg;
            end
            default:
            begin
                link_we = '0;
            end
        endcase
    end

    // Info memory write port
    always_comb
    begin
        info_we    = 1'b0;
        info_waddr = clr_reg;
        info_wdata = {(clr_reg == '0), 1'b0, {COUNT_WIDTH{1'b0}}};
        case (state_reg)
            S_CLR:
            begin
                info_we = 1'b1;
            end
            S_EVAL:
            begin
                info_we    = ev_iwe;
                info_waddr = ev_laddr;
                info_wdata = ev_idata;
            end
            S_W2:
            begin
                // successor's count, read during evaluation
                info_we    = inc_reg;
                info_waddr = running_reg;
                info_wdata = {rd_exists, rd_blocked, quanta_inc};
            end
            default:
            begin
                info_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            running_reg <= '0;
            tail_reg    <= NONE;
            total_reg   <= '0;
            inc_reg     <= 1'b0;
            b_we_reg    <= '0;
            c_we_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (state_reg == S_EVAL)
            begin
                running_reg <= running_next;
                tail_reg    <= tail_next;
                total_reg   <= total_next;
                inc_reg     <= inc_next;
                b_we_reg    <= b_we_next;
                c_we_reg    <= c_we_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg   <= in_op;
            id_reg   <= in_idx;
            idok_reg <= in_ok;
        end
        if (state_reg == S_EVAL)
        begin
            status_reg <= status_next;
            tq_reg     <= tq_next;
            b_addr_reg <= b_addr_next;
            b_nxt_reg  <= b_nxt_next;
            c_addr_reg <= c_addr_next;
            c_prv_reg  <= c_prv_next;
            c_nxt_reg  <= c_nxt_next;
        end
    end

    // Result item
    assign run_ext   = XW'(running_reg);
    assign tq_ext    = CXW'(tq_reg);
    assign total_ext = CXW'(total_reg);

    always_comb
    begin
        res.running_id    = run_ext[rrts_pkg::ID_W-1:0];
        res.status        = status_reg;
        res.thread_quanta = tq_ext[rrts_pkg::OUT_CNT_W-1:0];
        res.total_quanta  = total_ext[rrts_pkg::OUT_CNT_W-1:0];
    end

    // The running thread is never the queue tail
    assert property (@(posedge clk) disable iff (!rst_n) tail_reg != LW'(running_reg))
        else $error("running thread recorded as queue tail");

    // The total quantum count only changes in the evaluation cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_EVAL |=> $stable(total_reg))
        else $error("total count changed outside evaluation");

    // The running thread only changes in the evaluation cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_EVAL |=> $stable(running_reg))
        else $error("running thread changed outside evaluation");

    // One result per command, never on consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n) res_valid |=> !res_valid)
        else $error("result repeated");

endmodule

// ----- rtl/round_robin_thread_scheduler_core.sv -----
// Path: after its command transfer, a result passes the EVAL, W2 and W3 states, then the output register.
// The next command is taken only once the sequencer is back in idle, a pace set by its three write passes
// over the single write port of the link memory (read, evaluate, two follow-up writes).
// A finished result waits in the output register while the next command is taken.
// Reset: asynchronous, active low; afterwards a clearing pass over every thread entry
// initialises both memories with s_tready low, then thread 0 runs alone.
`timescale 1ns / 1ps

module round_robin_thread_scheduler_core #(
    parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF,
    parameter int COUNT_WIDTH = rrts_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rrts_pkg::S_TDATA_W-1:0] s_tdata,  // opcode[2:0], thread_id[8:3]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rrts_pkg::M_TDATA_W-1:0] m_tdata   // running_id[5:0], status[7:6],
                                                     // thread_quanta[39:8], total_quanta[71:40]
);

    localparam int TW = $clog2(MAX_THREADS);
    localparam int LW = TW + 1;
    localparam int DW = COUNT_WIDTH + 2;

    rrts_pkg::link_we_t link_we;
    logic [TW-1:0]      link_waddr, link_raddr;
    logic [LW-1:0]      link_wnext, link_wprev, link_rnext, link_rprev;
    logic               info_we;
    logic [TW-1:0]      info_waddr, info_raddr;
    logic [DW-1:0]      info_wdata, info_rdata;

    logic               res_ready, res_valid;
    rrts_pkg::result_t  res;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [rrts_pkg::M_TDATA_W-1:0] m_tdata_reg;

    rrts_seq #(
        .MAX_THREADS (MAX_THREADS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tdata[2:0]),
        .in_id      (s_tdata[8:3]),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wnext (link_wnext),
        .link_wprev (link_wprev),
        .link_raddr (link_raddr),
        .link_rnext (link_rnext),
        .link_rprev (link_rprev),
        .info_we    (info_we),
        .info_waddr (info_waddr),
        .info_wdata (info_wdata),
        .info_raddr (info_raddr),
        .info_rdata (info_rdata)
    );

    rrts_link_ram #(
        .MAX_THREADS (MAX_THREADS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wnext (link_wnext),
        .wprev (link_wprev),
        .raddr (link_raddr),
        .rnext (link_rnext),
        .rprev (link_rprev)
    );

    rrts_info_ram #(
        .MAX_THREADS (MAX_THREADS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_info_ram (
        .clk   (clk),
        .we    (info_we),
        .waddr (info_waddr),
        .wdata (info_wdata),
        .raddr (info_raddr),
        .rdata (info_rdata)
    );

    // Output register: free when empty or when its transfer completes
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Load the result, first field in the lowest bits
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_tdata_reg <= {res.total_quanta, res.thread_quanta, res.status, res.running_id};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
